/* rtl/wcms_pkg.sv */
// Shared types and constants for the wildcard multi-pattern scanner.
`default_nettype none

package wcms_pkg;

    localparam int DATA_W = 8;
    localparam int ADDR_W = 48;
    localparam int CNT_W  = 3;

    // Depth of the report queue between the compare stage and the output register.
    localparam int RPT_DEPTH = 4;

    typedef enum logic [2:0] {
        MODE_LOAD     = 3'd0,
        MODE_LENGTH   = 3'd1,
        MODE_SCAN     = 3'd2,
        MODE_BREAK    = 3'd3,
        MODE_NEW_SCAN = 3'd4
    } mode_t;

endpackage

`default_nettype wire

/* rtl/wildcard_multi_pattern_scanner_unit.sv */
// Top level of the wildcard multi-pattern byte scanner.
`default_nettype none

// Takes one item per clock while in_ready is high. A scanned byte shifts into a row of
// MAX_LEN window cells, and in the next cycle every active pattern is compared against
// the window at once; a byte that finds patterns pushes one entry into a 4-entry report
// queue, and the output register drains that queue at one report per cycle unless the
// receiver stalls, lowest pattern index first. A report goes from the compare stage
// through the report queue into the output register. in_ready drops only while the report
// queue, counting the byte in the compare stage, is full; a byte that finds k patterns
// gives k reports. Configuration writes are taken in every cycle.
module wildcard_multi_pattern_scanner_unit #(
    parameter int NUM_PATTERNS = 4,
    parameter int MAX_LEN      = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [wcms_pkg::CNT_W-1:0]  cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [2:0]                  mode,
    input  wire logic [1:0]                  pattern_index,
    input  wire logic [3:0]                  byte_position,
    input  wire logic [7:0]                  data_byte,
    input  wire logic                        wildcard_req,
    input  wire logic [4:0]                  pattern_length,
    input  wire logic [47:0]                 byte_address,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [1:0]                       found_pattern,
    output logic [47:0]                      match_address,
    output logic                             all_found,
    output logic                             last_of_run
);

    localparam int NP     = NUM_PATTERNS;
    localparam int DW     = wcms_pkg::DATA_W;
    localparam int AW     = wcms_pkg::ADDR_W;
    localparam int LW     = $clog2(MAX_LEN + 1);
    localparam int IW     = $clog2(MAX_LEN);
    localparam int PIW    = (NP > 1) ? $clog2(NP) : 1;
    localparam int QCW    = $clog2(wcms_pkg::RPT_DEPTH + 1);
    localparam int LENS_LO = 0;
    localparam int ADDR_LO = NP * LW;
    localparam int MASK_LO = ADDR_LO + AW;
    localparam int CPL_BIT = MASK_LO + NP;
    localparam int EW      = CPL_BIT + 1;

    // Handshake and decode
    logic in_fire, scan_fire, load_fire, len_fire, clear_fire, new_scan_fire;

    assign cfg_ready     = 1'b1;
    assign in_fire       = in_valid && in_ready;
    assign scan_fire     = in_fire && (mode == wcms_pkg::MODE_SCAN);
    assign load_fire     = in_fire && (mode == wcms_pkg::MODE_LOAD);
    assign len_fire      = in_fire && (mode == wcms_pkg::MODE_LENGTH);
    assign new_scan_fire = in_fire && (mode == wcms_pkg::MODE_NEW_SCAN);
    assign clear_fire    = new_scan_fire || (in_fire && (mode == wcms_pkg::MODE_BREAK));

    // Configuration, lengths, fill
    logic [wcms_pkg::CNT_W-1:0] cnt_reg;
    logic [LW-1:0] len_reg [NP];
    logic [LW-1:0] len_in;
    logic [LW-1:0] fill_reg, fill_next;

    always_comb
    begin
        if (pattern_length == 5'd0)
        begin
            len_in = LW'(1);
        end
        else if (32'(pattern_length) > MAX_LEN)
        begin
            len_in = LW'(MAX_LEN);
        end
        else
        begin
            len_in = LW'(pattern_length);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < NP; p++)
        begin
            if (len_fire && (32'(pattern_index) == p))
            begin
                len_reg[p] <= len_in;
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (clear_fire)
        begin
            fill_next = '0;
        end
        else if (scan_fire && (fill_reg != LW'(MAX_LEN)))
        begin
            fill_next = fill_reg + LW'(1);
        end
    end

    // Window cells
    logic [MAX_LEN-1:0][DW-1:0]         win;
    logic [MAX_LEN-1:0][NP-1:0][DW-1:0] cmp;
    logic [MAX_LEN-1:0][NP-1:0]         hit;
    logic [MAX_LEN-1:0][NP-1:0]         load_en;

    for (genvar i = 0; i < MAX_LEN; i++)
    begin : g_cell
        logic [DW-1:0] cell_in;
        if (i == 0)
        begin : g_head
            assign cell_in = data_byte;
        end
        else
        begin : g_body
            assign cell_in = win[i-1];
        end

        wcms_cell #(
            .NUM_PATTERNS(NP)
        ) u_cell (
            .clk      (clk),
            .shift_en (scan_fire),
            .win_in   (cell_in),
            .win_out  (win[i]),
            .load_en  (load_en[i]),
            .load_byte(data_byte),
            .load_wild(wildcard_req),
            .cmp_byte (cmp[i]),
            .hit      (hit[i])
        );
    end

    always_comb
    begin
        for (int i = 0; i < MAX_LEN; i++)
        begin
            for (int p = 0; p < NP; p++)
            begin
                load_en[i][p] = load_fire && (32'(pattern_index) == p)
                                && (32'(byte_position) == i);
            end
        end
    end

    // Pattern position i lines up with window byte len-1-i
    always_comb
    begin
        logic [LW-1:0] idx_full;
        idx_full = '0;
        for (int i = 0; i < MAX_LEN; i++)
        begin
            for (int p = 0; p < NP; p++)
            begin
                idx_full   = len_reg[p] - LW'(1) - LW'(i);
                cmp[i][p]  = win[idx_full[IW-1:0]];
            end
        end
    end

    // Compare stage: in the cycle after the byte shifted in
    logic          s2_valid_reg;
    logic [AW-1:0] s2_addr_reg;
    logic [NP-1:0] found_reg, found_next;
    logic [NP-1:0] match, amask, new_mask, flags_after;
    logic          already_done, run_complete, push;
    logic [EW-1:0] push_data;

    always_comb
    begin
        logic ok;
        ok = 1'b1;
        for (int p = 0; p < NP; p++)
        begin
            ok = 1'b1;
            for (int i = 0; i < MAX_LEN; i++)
            begin
                if (LW'(i) < len_reg[p])
                begin
                    ok = ok & hit[i][p];
                end
            end
            match[p] = ok && (len_reg[p] != '0) && (len_reg[p] <= fill_reg);
            // A count of zero still searches slot 0
            amask[p] = (p == 0) || (32'(p) < 32'(cnt_reg));
        end
    end

    always_comb
    begin
        already_done = ((found_reg & amask) == amask);
        new_mask     = (s2_valid_reg && !already_done) ? (match & ~found_reg & amask) : '0;
        flags_after  = found_reg | new_mask;
        run_complete = ((flags_after & amask) == amask);
        push         = (new_mask != '0);
        for (int p = 0; p < NP; p++)
        begin
            push_data[LENS_LO + p*LW +: LW] = len_reg[p];
        end
        push_data[ADDR_LO +: AW] = s2_addr_reg;
        push_data[MASK_LO +: NP] = new_mask;
        push_data[CPL_BIT]       = run_complete;
        // New scan accepted in the same cycle wins over the flags set here
        found_next = new_scan_fire ? '0 : flags_after;
    end

    always_ff @(posedge clk)
    begin
        if (scan_fire)
        begin
            s2_addr_reg <= byte_address;
        end
    end

    // Report queue
    logic [EW-1:0]  head_data;
    logic [QCW-1:0] q_count;
    logic           pop;

    wcms_rpt_fifo #(
        .WIDTH(EW),
        .DEPTH(wcms_pkg::RPT_DEPTH)
    ) u_rpt_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .head_data(head_data),
        .count    (q_count)
    );

    assign in_ready = (32'(q_count) + 32'(s2_valid_reg)) < wcms_pkg::RPT_DEPTH;

    // Output stage: emit the head entry's reports lowest index first
    logic [NP-1:0]  done_reg, done_next;
    logic [NP-1:0]  rem, pick_oh, rem_after;
    logic [PIW-1:0] pick;
    logic [LW-1:0]  pick_len;
    logic           emit, is_last;
    logic           out_valid_reg, out_valid_next;
    logic [1:0]     found_pattern_reg;
    logic [AW-1:0]  match_address_reg;
    logic           all_found_reg, last_of_run_reg;

    always_comb
    begin
        rem  = head_data[MASK_LO +: NP] & ~done_reg;
        pick = '0;
        for (int p = NP - 1; p >= 0; p--)
        begin
            if (rem[p])
            begin
                pick = PIW'(p);
            end
        end
        pick_oh   = NP'(1) << pick;
        rem_after = rem & ~pick_oh;
        is_last   = (rem_after == '0);
        pick_len  = head_data[LENS_LO + pick*LW +: LW];
        emit      = (q_count != '0) && (!out_valid_reg || out_ready);
        pop       = emit && is_last;

        done_next = done_reg;
        if (emit)
        begin
            done_next = is_last ? '0 : (done_reg | pick_oh);
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            found_pattern_reg <= 2'(pick);
            match_address_reg <= head_data[ADDR_LO +: AW] + AW'(1) - AW'(pick_len);
            all_found_reg     <= is_last && head_data[CPL_BIT];
            last_of_run_reg   <= is_last;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= wcms_pkg::CNT_W'(1);
            fill_reg      <= '0;
            found_reg     <= '0;
            s2_valid_reg  <= 1'b0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cnt_reg <= cfg_data;
            end
            fill_reg      <= fill_next;
            found_reg     <= found_next;
            s2_valid_reg  <= scan_fire;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found_pattern = found_pattern_reg;
    assign match_address = match_address_reg;
    assign all_found     = all_found_reg;
    assign last_of_run   = last_of_run_reg;

endmodule

`default_nettype wire

/* rtl/wcms_cell.sv */
// One window cell: a window byte that shifts to the next cell, and the pattern bytes at its position.
`default_nettype none

module wcms_cell #(
    parameter int NUM_PATTERNS = 4
) (
    input  wire logic                                         clk,
    input  wire logic                                         shift_en,
    input  wire logic [wcms_pkg::DATA_W-1:0]                  win_in,
    output logic      [wcms_pkg::DATA_W-1:0]                  win_out,
    input  wire logic [NUM_PATTERNS-1:0]                      load_en,
    input  wire logic [wcms_pkg::DATA_W-1:0]                  load_byte,
    input  wire logic                                         load_wild,
    input  wire logic [NUM_PATTERNS-1:0][wcms_pkg::DATA_W-1:0] cmp_byte,
    output logic      [NUM_PATTERNS-1:0]                      hit
);

    logic [wcms_pkg::DATA_W-1:0] win_reg;
    logic [NUM_PATTERNS-1:0][wcms_pkg::DATA_W-1:0] pat_reg;
    logic [NUM_PATTERNS-1:0] wild_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            win_reg <= win_in;
        end
        for (int p = 0; p < NUM_PATTERNS; p++)
        begin
            if (load_en[p])
            begin
                pat_reg[p]  <= load_byte;
                wild_reg[p] <= load_wild;
            end
        end
    end

    assign win_out = win_reg;

    always_comb
    begin
        for (int p = 0; p < NUM_PATTERNS; p++)
        begin
            hit[p] = wild_reg[p] || (pat_reg[p] == cmp_byte[p]);
        end
    end

endmodule

`default_nettype wire

/* rtl/wcms_rpt_fifo.sv */
// Report queue: holds one entry per scanned byte that found at least one pattern not yet found in the run.
`default_nettype none

module wcms_rpt_fifo #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           push_data,
    input  wire logic                       pop,
    output logic      [WIDTH-1:0]           head_data,
    output logic      [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head_data = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

`default_nettype wire

/* verif/wcms_checker.sv */
// Scoreboard for the scanner: follows accepted transactions, predicts reports, compares them.
module wcms_checker #(
    parameter int NUM_PATTERNS = 4,
    parameter int MAX_LEN      = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [wcms_pkg::CNT_W-1:0]        cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [2:0]                        mode,
    input  logic [1:0]                        pattern_index,
    input  logic [3:0]                        byte_position,
    input  logic [wcms_pkg::DATA_W-1:0]       data_byte,
    input  logic                              wildcard_req,
    input  logic [4:0]                        pattern_length,
    input  logic [wcms_pkg::ADDR_W-1:0]       byte_address,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [1:0]                        found_pattern,
    input  logic [wcms_pkg::ADDR_W-1:0]       match_address,
    input  logic                              all_found,
    input  logic                              last_of_run,
    output int                                mismatch_total,
    output int                                reports_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W = wcms_pkg::DATA_W;
    localparam int ADDR_W = wcms_pkg::ADDR_W;
    localparam int CNT_W  = wcms_pkg::CNT_W;

    typedef struct packed {
        logic [1:0]        slot;
        logic [ADDR_W-1:0] start_addr;
        logic              all_hit;
        logic              run_end;
    } report_t;

    report_t                 owed_q[$];
    logic [DATA_W-1:0]       window_q [MAX_LEN];
    int unsigned             fill_level;
    logic [DATA_W-1:0]       sig_byte [NUM_PATTERNS][MAX_LEN];
    logic                    sig_wild [NUM_PATTERNS][MAX_LEN];
    int unsigned             sig_len [NUM_PATTERNS];
    logic [NUM_PATTERNS-1:0] found_set;
    logic [CNT_W-1:0]        count_reg;
    int                      fails;
    int                      reports_seen;

    function automatic int unsigned active_slots();
        if (count_reg == 0)
            return 1;
        if (count_reg > NUM_PATTERNS)
            return NUM_PATTERNS;
        return count_reg;
    endfunction

    function automatic bit sig_hit(int p);
        int unsigned len;
        len = sig_len[p];
        if (len == 0 || len > MAX_LEN || len > fill_level)
            return 1'b0;
        for (int i = 0; i < len; i++)
        begin
            if (!sig_wild[p][i] && sig_byte[p][i] != window_q[len - 1 - i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_window();
        foreach (window_q[k])
            window_q[k] = '0;
        fill_level = 0;
    endtask

    task automatic scan_byte(input logic [DATA_W-1:0] b, input logic [ADDR_W-1:0] addr);
        int unsigned             cnt;
        logic [NUM_PATTERNS-1:0] mask;
        logic [NUM_PATTERNS-1:0] new_hits;
        report_t                 r;
        for (int k = MAX_LEN - 1; k > 0; k--)
            window_q[k] = window_q[k - 1];
        window_q[0] = b;
        if (fill_level < MAX_LEN)
            fill_level++;
        cnt  = active_slots();
        mask = NUM_PATTERNS'((1 << cnt) - 1);
        if ((found_set & mask) == mask)
            return;
        new_hits = '0;
        for (int p = 0; p < cnt; p++)
        begin
            if (!found_set[p] && sig_hit(p))
                new_hits[p] = 1'b1;
        end
        // Reports leave in index order; the highest new hit closes the run.
        for (int p = 0; p < cnt; p++)
        begin
            if (!new_hits[p])
                continue;
            found_set[p] = 1'b1;
            r.slot       = 2'(p);
            r.start_addr = addr - ADDR_W'(sig_len[p]) + 1'b1;
            r.all_hit    = ((found_set & mask) == mask);
            r.run_end    = ((new_hits >> (p + 1)) == 0);
            owed_q.push_back(r);
        end
    endtask

    task automatic take_item();
        case (mode)
            wcms_pkg::MODE_LOAD:
            begin
                sig_byte[pattern_index][byte_position] = data_byte;
                sig_wild[pattern_index][byte_position] = wildcard_req;
            end
            wcms_pkg::MODE_LENGTH:
            begin
                if (pattern_length == 0)
                    sig_len[pattern_index] = 1;
                else if (pattern_length > MAX_LEN)
                    sig_len[pattern_index] = MAX_LEN;
                else
                    sig_len[pattern_index] = pattern_length;
            end
            wcms_pkg::MODE_SCAN:
                scan_byte(data_byte, byte_address);
            wcms_pkg::MODE_BREAK:
                clear_window();
            wcms_pkg::MODE_NEW_SCAN:
            begin
                clear_window();
                found_set = '0;
            end
            default:
                ;
        endcase
    endtask

    task automatic check_report();
        report_t want;
        reports_seen++;
        if (owed_q.size() == 0)
        begin
            if (fails < 10)
                $display("report %0d unexpected: pattern %0d addr %h all %0b last %0b",
                         reports_seen, found_pattern, match_address, all_found, last_of_run);
            fails++;
            return;
        end
        want = owed_q.pop_front();
        if (found_pattern !== want.slot || match_address !== want.start_addr ||
            all_found !== want.all_hit || last_of_run !== want.run_end)
        begin
            if (fails < 10)
                $display("report %0d mismatch: expected pattern %0d addr %h all %0b last %0b, %s",
                         reports_seen, want.slot, want.start_addr, want.all_hit, want.run_end,
                         $sformatf("got pattern %0d addr %h all %0b last %0b",
                                   found_pattern, match_address, all_found, last_of_run));
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_q.delete();
            clear_window();
            foreach (sig_len[p])
                sig_len[p] = 0;
            found_set      = '0;
            count_reg      = 1;
            fails          = 0;
            reports_seen   = 0;
            mismatch_total <= 0;
            reports_owed   <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                count_reg = cfg_data;
            if (in_valid && in_ready)
                take_item();
            if (out_valid && out_ready)
                check_report();
            mismatch_total <= fails;
            reports_owed   <= owed_q.size();
        end
    end

endmodule

/* verif/wildcard_multi_pattern_scanner_unit_tb.sv */
// Testbench top for the scanner: stimulus, receiver stalls, watchdog and verdict.
module wildcard_multi_pattern_scanner_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W          = wcms_pkg::DATA_W;
    localparam int ADDR_W          = wcms_pkg::ADDR_W;
    localparam int CNT_W           = wcms_pkg::CNT_W;
    localparam int NUM_PATTERNS    = 4;
    localparam int MAX_LEN         = 16;
    localparam int RANDOM_ITEMS    = 400;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 4000;

    typedef struct packed {
        logic [2:0]        op;
        logic [1:0]        slot;
        logic [3:0]        pos;
        logic [DATA_W-1:0] data;
        logic              wild;
        logic [4:0]        len;
        logic [ADDR_W-1:0] addr;
    } item_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [2:0]        mode;
    logic [1:0]        pattern_index;
    logic [3:0]        byte_position;
    logic [DATA_W-1:0] data_byte;
    logic              wildcard_req;
    logic [4:0]        pattern_length;
    logic [ADDR_W-1:0] byte_address;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        found_pattern;
    logic [ADDR_W-1:0] match_address;
    logic              all_found;
    logic              last_of_run;
    int                mismatch_total;
    int                reports_owed;

    // Stimulus-side copy of the tables, used only to plant known signatures in the stream.
    logic [DATA_W-1:0] sig_copy [NUM_PATTERNS][MAX_LEN];
    logic              wild_copy [NUM_PATTERNS][MAX_LEN];
    int                len_copy [NUM_PATTERNS];
    int                active_cfg;
    int                burst_left;
    int                random_sent;
    bit                tally_on;
    bit                hold_off_req;
    bit                hold_off_done;
    int                idle_cycles;

    wildcard_multi_pattern_scanner_unit #(
        .NUM_PATTERNS (NUM_PATTERNS),
        .MAX_LEN      (MAX_LEN)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .pattern_index  (pattern_index),
        .byte_position  (byte_position),
        .data_byte      (data_byte),
        .wildcard_req   (wildcard_req),
        .pattern_length (pattern_length),
        .byte_address   (byte_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found_pattern  (found_pattern),
        .match_address  (match_address),
        .all_found      (all_found),
        .last_of_run    (last_of_run)
    );

    wcms_checker #(
        .NUM_PATTERNS (NUM_PATTERNS),
        .MAX_LEN      (MAX_LEN)
    ) u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .pattern_index  (pattern_index),
        .byte_position  (byte_position),
        .data_byte      (data_byte),
        .wildcard_req   (wildcard_req),
        .pattern_length (pattern_length),
        .byte_address   (byte_address),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found_pattern  (found_pattern),
        .match_address  (match_address),
        .all_found      (all_found),
        .last_of_run    (last_of_run),
        .mismatch_total (mismatch_total),
        .reports_owed   (reports_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int clamp_count(int v);
        if (v == 0)
            return 1;
        return (v > NUM_PATTERNS) ? NUM_PATTERNS : v;
    endfunction

    function automatic item_t any_item();
        item_t it;
        it.op   = 3'($urandom_range(0, 7));
        it.slot = 2'($urandom);
        it.pos  = 4'($urandom);
        it.data = 8'($urandom);
        it.wild = 1'($urandom);
        it.len  = 5'($urandom);
        it.addr = ADDR_W'({$urandom, $urandom});
        return it;
    endfunction

    function automatic item_t mk_op(logic [2:0] op);
        item_t it;
        it    = any_item();
        it.op = op;
        return it;
    endfunction

    function automatic item_t mk_load(int slot, int pos, logic [7:0] data, logic wild);
        item_t it;
        it      = mk_op(wcms_pkg::MODE_LOAD);
        it.slot = 2'(slot);
        it.pos  = 4'(pos);
        it.data = data;
        it.wild = wild;
        return it;
    endfunction

    function automatic item_t mk_len(int slot, logic [4:0] len);
        item_t it;
        it      = mk_op(wcms_pkg::MODE_LENGTH);
        it.slot = 2'(slot);
        it.len  = len;
        return it;
    endfunction

    function automatic item_t mk_scan(logic [7:0] data, logic [ADDR_W-1:0] addr);
        item_t it;
        it      = mk_op(wcms_pkg::MODE_SCAN);
        it.data = data;
        it.addr = addr;
        return it;
    endfunction

    function automatic logic [4:0] pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return 5'($urandom_range(1, 5));
        if (r < 17)
            return 5'($urandom_range(6, MAX_LEN));
        return ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(MAX_LEN + 1, 31));
    endfunction

    function automatic logic [7:0] stream_byte();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom);
        return 8'h30 + 8'($urandom_range(0, 3));
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send(item_t it);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                    : $urandom_range(1, 10);
        end
        mode           <= it.op;
        pattern_index  <= it.slot;
        byte_position  <= it.pos;
        data_byte      <= it.data;
        wildcard_req   <= it.wild;
        pattern_length <= it.len;
        byte_address   <= it.addr;
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        burst_left--;
        if (it.op == wcms_pkg::MODE_LOAD)
        begin
            sig_copy[it.slot][it.pos]  = it.data;
            wild_copy[it.slot][it.pos] = it.wild;
        end
        else if (it.op == wcms_pkg::MODE_LENGTH)
            len_copy[it.slot] = (it.len == 0) ? 1 : ((it.len > MAX_LEN) ? MAX_LEN : it.len);
        if (tally_on)
            random_sent++;
    endtask

    // Drop valid, let every owed report drain, then cover bytes still in flight.
    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (reports_owed != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_count(int v);
        wait_idle();
        cfg_data  <= CNT_W'(v);
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid  <= 1'b0;
        active_cfg = clamp_count(v);
    endtask

    task automatic program_slot(int slot, logic [4:0] raw_len, bit narrow);
        int eff;
        eff = (raw_len == 0) ? 1 : ((raw_len > MAX_LEN) ? MAX_LEN : raw_len);
        for (int i = 0; i < eff; i++)
            send(mk_load(slot, i, narrow ? stream_byte() : 8'($urandom),
                         ($urandom_range(0, 4) == 0)));
        send(mk_len(slot, raw_len));
    endtask

    task automatic run_episode();
        int                n_bytes;
        int                pick;
        int                s;
        logic [ADDR_W-1:0] addr;
        if ($urandom_range(0, 2) == 0)
            write_count($urandom_range(0, 7));
        repeat ($urandom_range(0, 2))
            program_slot($urandom_range(0, NUM_PATTERNS - 1), pick_len(),
                         $urandom_range(0, 3) != 0);
        send(mk_op(($urandom_range(0, 3) == 0) ? wcms_pkg::MODE_BREAK
                                               : wcms_pkg::MODE_NEW_SCAN));
        if ($urandom_range(0, 7) == 0)
            addr = {ADDR_W{1'b1}} - ADDR_W'($urandom_range(0, 8));
        else
            addr = ADDR_W'({$urandom, $urandom});
        n_bytes = $urandom_range(4, 30);
        for (int b = 0; b < n_bytes; b++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                // Plant a copy of an active signature, wildcards filled at random.
                s = $urandom_range(0, active_cfg - 1);
                for (int i = 0; i < len_copy[s]; i++)
                begin
                    send(mk_scan(wild_copy[s][i] ? stream_byte() : sig_copy[s][i], addr));
                    addr++;
                end
            end
            else if (pick < 15)
                send(mk_op(wcms_pkg::MODE_BREAK));
            else if (pick < 18)
                send(mk_op(wcms_pkg::MODE_NEW_SCAN));
            else if (pick < 21)
                send(mk_op(3'($urandom_range(wcms_pkg::MODE_NEW_SCAN + 1, 7))));
            else if (pick < 24)
                send(mk_load($urandom_range(0, NUM_PATTERNS - 1), $urandom_range(0, MAX_LEN - 1),
                             stream_byte(), ($urandom_range(0, 4) == 0)));
            else
            begin
                send(mk_scan(stream_byte(), addr));
                addr++;
            end
        end
    endtask

    initial
    begin : stimulus
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        mode           = wcms_pkg::MODE_LOAD;
        pattern_index  = '0;
        byte_position  = '0;
        data_byte      = '0;
        wildcard_req   = 1'b0;
        pattern_length = '0;
        byte_address   = '0;
        hold_off_req   = 1'b0;
        tally_on       = 1'b0;
        random_sent    = 0;
        burst_left     = 0;
        active_cfg     = 1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        tally_on = 1'b1;

        // Fill every table entry before anything is scanned.
        for (int p = 0; p < NUM_PATTERNS; p++)
        begin
            send(mk_len(p, 5'(MAX_LEN)));
            for (int i = 0; i < MAX_LEN; i++)
                send(mk_load(p, i, 8'($urandom), 1'($urandom)));
        end

        write_count(NUM_PATTERNS);
        send(mk_len(0, 5'd0));
        send(mk_load(0, 0, 8'hFF, 1'b0));
        send(mk_len(1, 5'd2));
        send(mk_load(1, 0, 8'h00, 1'b0));
        send(mk_load(1, 1, 8'h5A, 1'b1));
        send(mk_len(2, 5'd31));
        send(mk_len(3, 5'd1));
        send(mk_load(3, MAX_LEN - 1, 8'hAA, 1'b1));
        send(mk_load(3, 0, 8'h00, 1'b1));
        send(mk_op(wcms_pkg::MODE_NEW_SCAN + 3'd1));
        send(mk_op(wcms_pkg::MODE_NEW_SCAN + 3'd2));
        send(mk_op(wcms_pkg::MODE_NEW_SCAN + 3'd3));
        send(mk_op(wcms_pkg::MODE_NEW_SCAN));
        send(mk_scan(8'h00, {ADDR_W{1'b1}}));
        // Two-byte signature ending at address zero: start address wraps.
        send(mk_scan(8'h77, '0));
        send(mk_op(wcms_pkg::MODE_BREAK));
        send(mk_scan(8'hFF, ADDR_W'(5)));
        send(mk_op(wcms_pkg::MODE_NEW_SCAN));
        send(mk_scan(8'hFF, ADDR_W'(100)));
        write_count(0);
        send(mk_op(wcms_pkg::MODE_NEW_SCAN));
        send(mk_scan(8'hFF, ADDR_W'(200)));
        send(mk_scan(8'hFF, ADDR_W'(201)));
        write_count(7);
        send(mk_scan(8'h00, ADDR_W'(202)));

        // Single-byte signatures, one of which fires on every scanned byte, while the receiver holds off.
        write_count(NUM_PATTERNS);
        for (int p = 0; p < NUM_PATTERNS; p++)
        begin
            send(mk_load(p, 0, 8'h10 + 8'(p), 1'b0));
            send(mk_len(p, 5'd1));
        end
        hold_off_req = 1'b1;
        repeat (30)
        begin
            send(mk_op(wcms_pkg::MODE_NEW_SCAN));
            send(mk_scan(8'h10 + 8'($urandom_range(0, 3)), ADDR_W'({$urandom, $urandom})));
        end

        while (random_sent < RANDOM_ITEMS)
            run_episode();
        write_count(1);

        wait_idle();
        if (mismatch_total == 0 && reports_owed == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : receiver
        int style;
        int span;
        int phase;
        out_ready     = 1'b0;
        hold_off_done = 1'b0;
        forever
        begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(8, 60);
            for (phase = 0; phase < span; phase++)
            begin
                @(negedge clk);
                if (hold_off_req && !hold_off_done)
                begin
                    out_ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(negedge clk);
                    hold_off_done = 1'b1;
                end
                case (style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom);
                    2:       out_ready <= (phase % 4 == 3);
                    default: out_ready <= ($urandom_range(0, 6) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
        else
            idle_cycles <= 0;
    end

endmodule

/* filelist.f */
rtl/wcms_pkg.sv
rtl/wcms_cell.sv
rtl/wcms_rpt_fifo.sv
rtl/wildcard_multi_pattern_scanner_unit.sv
verif/wcms_checker.sv
verif/wildcard_multi_pattern_scanner_unit_tb.sv
